### hw/rtl/mte_pkg.sv
package mte_pkg;

    localparam int ANGLE_W    = 32;
    localparam int DIST_W     = 33;
    localparam int RATE_W     = 24;
    localparam int SETTLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE      = 3'd0,
        REG_YAW_SPEED   = 3'd1,
        REG_YAW_ACCEL   = 3'd2,
        REG_PITCH_SPEED = 3'd3,
        REG_PITCH_ACCEL = 3'd4,
        REG_SETTLE_MS   = 3'd5
    } cfg_reg_t;

    localparam logic [RATE_W-1:0]   RST_SPEED  = 24'd184320;
    localparam logic [RATE_W-1:0]   RST_ACCEL  = 24'd368640;

    // yaw wrap: 368640 = 45 * 2^13
    localparam logic [18:0] TURN_UNITS  = 19'd368640;
    localparam int          LO_BITS     = 13;
    localparam logic [20:0] WRAP_OFFSET = 21'd524295;
    localparam logic [21:0] RECIP45     = 22'd2982616;
    localparam int          RECIP_SHIFT = 27;
    localparam logic [6:0]  COARSE_MOD  = 7'd45;

    // 4e12 = 5^12 * 2^14, 1e6 = 15625 * 2^6
    localparam logic [27:0] TRI_SCALE  = 28'd244140625;
    localparam int          TRI_SHIFT  = 14;
    localparam logic [13:0] TRAP_SCALE = 14'd15625;
    localparam int          TRAP_SHIFT = 6;

    localparam int NUM_W      = 78;
    localparam int DEN_W      = 48;
    localparam int QUO_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 34;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    localparam logic [QUO_W-1:0]  TRAP_SAT_LIMIT = 64'd4294967290;
    localparam logic [TIME_W-1:0] TIME_SAT       = 32'hFFFF_FFFF;
    localparam logic [9:0]        MS_TO_US       = 10'd1000;

    typedef struct packed {
        logic [RATE_W-1:0] speed;
        logic [RATE_W-1:0] accel;
    } axis_cfg_t;

endpackage

### hw/rtl/mte_axis.sv
module mte_axis import mte_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DIST_W-1:0] distance,
    input  axis_cfg_t         cfg,
    output logic              out_valid,
    output logic [TIME_W-1:0] time_us
);

    // products
    logic              a1_valid_reg;
    logic              a1_zero_reg;
    logic [56:0]       a1_da_reg;
    logic [47:0]       a1_vv_reg;
    logic [DEN_W-1:0]  a1_va_reg;
    logic [60:0]       a1_dk_reg;

    // profile choice
    logic              a2_valid_reg;
    logic              a2_zero_reg;
    logic              a2_tri_reg;
    logic [57:0]       a2_sum_reg;
    logic [DEN_W-1:0]  a2_va_reg;
    logic [60:0]       a2_dk_reg;

    logic [71:0]       a3_trap_prod;
    logic [NUM_W-1:0]  a3_num;
    logic [DEN_W-1:0]  a3_den;

    // divider stages
    logic              dv_valid_reg [0:DIV_STEPS];
    logic              dv_zero_reg  [0:DIV_STEPS];
    logic              dv_tri_reg   [0:DIV_STEPS];
    logic              dv_sat_reg   [0:DIV_STEPS];
    logic [DEN_W-1:0]  dv_rem_reg   [0:DIV_STEPS];
    logic [QUO_W-1:0]  dv_w_reg     [0:DIV_STEPS];
    logic [DEN_W-1:0]  dv_den_reg   [0:DIV_STEPS];
    logic [DEN_W-1:0]  dv_rem_next  [0:DIV_STEPS-1];
    logic              dv_bit_next  [0:DIV_STEPS-1];
    logic              dv_sat_next  [0:DIV_STEPS-1];

    // square root stages
    logic              sq_valid_reg [0:SQRT_STEPS];
    logic              sq_zero_reg  [0:SQRT_STEPS];
    logic              sq_tri_reg   [0:SQRT_STEPS];
    logic              sq_sat_reg   [0:SQRT_STEPS];
    logic [SQ_REM_W-1:0] sq_rem_reg [0:SQRT_STEPS];
    logic [QUO_W-1:0]  sq_w_reg     [0:SQRT_STEPS];
    logic [ROOT_W-1:0] sq_root_reg  [0:SQRT_STEPS];
    logic [TIME_W-1:0] sq_trap_reg  [0:SQRT_STEPS];
    logic [SQ_REM_W-1:0] sq_rem_next [0:SQRT_STEPS-1];
    logic              sq_bit_next  [0:SQRT_STEPS-1];

    logic [TIME_W-1:0] trap_time;
    logic [TIME_W-1:0] time_next;
    logic              out_valid_reg;
    logic [TIME_W-1:0] time_reg;

    assign a3_trap_prod = 72'(a2_sum_reg) * 72'(TRAP_SCALE);
    assign a3_num = a2_tri_reg ? {3'b0, a2_dk_reg, {TRI_SHIFT{1'b0}}}
                               : {a3_trap_prod, {TRAP_SHIFT{1'b0}}};
    assign a3_den = a2_tri_reg ? DEN_W'(cfg.accel) : a2_va_reg;

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [DEN_W:0] trial;
            trial          = {dv_rem_reg[k], dv_w_reg[k][QUO_W-1]};
            dv_bit_next[k] = trial >= {1'b0, dv_den_reg[k]};
            dv_rem_next[k] = dv_bit_next[k] ? DEN_W'(trial - {1'b0, dv_den_reg[k]})
                                            : DEN_W'(trial);
            dv_sat_next[k] = (k == 0) ? (dv_rem_reg[0] >= dv_den_reg[0]) : dv_sat_reg[k];
        end
    end

    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            logic [SQ_REM_W+1:0] cur;
            logic [SQ_REM_W+1:0] trial;
            cur            = {sq_rem_reg[k], sq_w_reg[k][QUO_W-1 -: 2]};
            trial          = {2'b0, sq_root_reg[k], 2'b01};
            sq_bit_next[k] = cur >= trial;
            sq_rem_next[k] = sq_bit_next[k] ? SQ_REM_W'(cur - trial) : SQ_REM_W'(cur);
        end
    end

    assign trap_time = (dv_sat_reg[DIV_STEPS] || dv_w_reg[DIV_STEPS] >= TRAP_SAT_LIMIT)
                       ? TIME_SAT : dv_w_reg[DIV_STEPS][TIME_W-1:0];

    always_comb begin
        priority if (sq_zero_reg[SQRT_STEPS]) begin
            time_next = '0;
        end else if (!sq_tri_reg[SQRT_STEPS]) begin
            time_next = sq_trap_reg[SQRT_STEPS];
        end else if (sq_sat_reg[SQRT_STEPS]) begin
            time_next = TIME_SAT;
        end else begin
            time_next = sq_root_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) dv_valid_reg[k] <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) sq_valid_reg[k] <= 1'b0;
        end else if (adv) begin
            a1_valid_reg    <= in_valid;
            a2_valid_reg    <= a1_valid_reg;
            dv_valid_reg[0] <= a2_valid_reg;
            for (int k = 0; k < DIV_STEPS; k++) dv_valid_reg[k+1] <= dv_valid_reg[k];
            sq_valid_reg[0] <= dv_valid_reg[DIV_STEPS];
            for (int k = 0; k < SQRT_STEPS; k++) sq_valid_reg[k+1] <= sq_valid_reg[k];
            out_valid_reg   <= sq_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_zero_reg <= (distance == '0);
            a1_da_reg   <= 57'(distance) * 57'(cfg.accel);
            a1_vv_reg   <= 48'(cfg.speed) * 48'(cfg.speed);
            a1_va_reg   <= 48'(cfg.speed) * 48'(cfg.accel);
            a1_dk_reg   <= 61'(distance) * 61'(TRI_SCALE);

            a2_zero_reg <= a1_zero_reg;
            a2_tri_reg  <= a1_da_reg <= 57'(a1_vv_reg);
            a2_sum_reg  <= 58'(a1_da_reg) + 58'(a1_vv_reg);
            a2_va_reg   <= a1_va_reg;
            a2_dk_reg   <= a1_dk_reg;

            dv_zero_reg[0] <= a2_zero_reg;
            dv_tri_reg[0]  <= a2_tri_reg;
            dv_sat_reg[0]  <= 1'b0;
            dv_rem_reg[0]  <= DEN_W'(a3_num[NUM_W-1:QUO_W]);
            dv_w_reg[0]    <= a3_num[QUO_W-1:0];
            dv_den_reg[0]  <= a3_den;
            for (int k = 0; k < DIV_STEPS; k++) begin
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_tri_reg[k+1]  <= dv_tri_reg[k];
                dv_sat_reg[k+1]  <= dv_sat_next[k];
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_w_reg[k+1]    <= {dv_w_reg[k][QUO_W-2:0], dv_bit_next[k]};
                dv_den_reg[k+1]  <= dv_den_reg[k];
            end

            sq_zero_reg[0] <= dv_zero_reg[DIV_STEPS];
            sq_tri_reg[0]  <= dv_tri_reg[DIV_STEPS];
            sq_sat_reg[0]  <= dv_sat_reg[DIV_STEPS];
            sq_rem_reg[0]  <= '0;
            sq_w_reg[0]    <= dv_w_reg[DIV_STEPS];
            sq_root_reg[0] <= '0;
            sq_trap_reg[0] <= trap_time;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_tri_reg[k+1]  <= sq_tri_reg[k];
                sq_sat_reg[k+1]  <= sq_sat_reg[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_w_reg[k+1]    <= {sq_w_reg[k][QUO_W-3:0], 2'b00};
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], sq_bit_next[k]};
                sq_trap_reg[k+1] <= sq_trap_reg[k];
            end

            time_reg <= time_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign time_us   = time_reg;

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid_reg[DIV_STEPS] && !dv_sat_reg[DIV_STEPS]
        |-> dv_rem_reg[DIV_STEPS] < dv_den_reg[DIV_STEPS])
        else $error("divider remainder not below divisor");

    a_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && sq_valid_reg[SQRT_STEPS] && sq_zero_reg[SQRT_STEPS] |=> time_reg == '0)
        else $error("zero distance gave nonzero time");

endmodule

### hw/rtl/gimbal_move_time_estimator.sv
// Gimbal move-time estimator.
// s_ channel: one beat carries current and target yaw/pitch angles
// (1/1024 degree, two's complement). m_ channel: one beat per input
// beat with yaw, pitch and total move times in microseconds.
// cfg_we/cfg_index/cfg_wdata write the limits; write only while idle.
// Each beat passes through the wrap and multiply stages, then the
// 64-step quotient pipeline and the 32-step square root pipeline.
// Throughput: one beat per cycle unless the receiver stalls the
// output; every stage advances together.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// default limits with the block enabled.
// When the receiver holds m_tready low while m_tvalid is high, the
// whole pipeline freezes and s_tready drops; nothing is lost or repeated.
module gimbal_move_time_estimator import mte_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // current_yaw, current_pitch, target_yaw, target_pitch
    input  logic [127:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // yaw_time_us, pitch_time_us, total_time_us
    output logic [95:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                enable_reg;
    logic [RATE_W-1:0]   yaw_speed_reg;
    logic [RATE_W-1:0]   yaw_accel_reg;
    logic [RATE_W-1:0]   pitch_speed_reg;
    logic [RATE_W-1:0]   pitch_accel_reg;
    logic [SETTLE_W-1:0] settle_reg;

    logic adv;

    logic [ANGLE_W-1:0] cur_yaw, cur_pitch, tgt_yaw, tgt_pitch;

    logic                s1_valid_reg;
    logic [DIST_W-1:0]   s1_dy_reg;
    logic [DIST_W-1:0]   s1_dp_reg;

    logic [42:0]         s2_prod;
    logic [20:0]         s2_u;
    logic                s2_valid_reg;
    logic [20:0]         s2_u_reg;
    logic [LO_BITS-1:0]  s2_lo_reg;
    logic [15:0]         s2_qest_reg;
    logic [DIST_W-1:0]   s2_pd_reg;

    logic [21:0]         s3_r_raw;
    logic [6:0]          s3_r;
    logic                s3_valid_reg;
    logic [18:0]         s3_m_reg;
    logic [DIST_W-1:0]   s3_pd_reg;

    logic [18:0]         s4_m_alt;
    logic                s4_valid_reg;
    logic [DIST_W-1:0]   s4_yd_reg;
    logic [DIST_W-1:0]   s4_pd_reg;

    axis_cfg_t           yaw_cfg, pitch_cfg;
    logic                yaw_valid, pitch_valid;
    logic [TIME_W-1:0]   yaw_time, pitch_time;

    logic [TIME_W-1:0]   big_time;
    logic [25:0]         settle_us;
    logic [TIME_W:0]     total_sum;
    logic [TIME_W-1:0]   total_time;

    logic                m_valid_reg;
    logic [95:0]         m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            yaw_speed_reg   <= RST_SPEED;
            yaw_accel_reg   <= RST_ACCEL;
            pitch_speed_reg <= RST_SPEED;
            pitch_accel_reg <= RST_ACCEL;
            settle_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE:      enable_reg      <= cfg_wdata[0];
                REG_YAW_SPEED:   yaw_speed_reg   <= cfg_wdata;
                REG_YAW_ACCEL:   yaw_accel_reg   <= cfg_wdata;
                REG_PITCH_SPEED: pitch_speed_reg <= cfg_wdata;
                REG_PITCH_ACCEL: pitch_accel_reg <= cfg_wdata;
                REG_SETTLE_MS:   settle_reg      <= cfg_wdata[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero limit acts as one
    assign yaw_cfg.speed   = (yaw_speed_reg   == '0) ? RATE_W'(1) : yaw_speed_reg;
    assign yaw_cfg.accel   = (yaw_accel_reg   == '0) ? RATE_W'(1) : yaw_accel_reg;
    assign pitch_cfg.speed = (pitch_speed_reg == '0) ? RATE_W'(1) : pitch_speed_reg;
    assign pitch_cfg.accel = (pitch_accel_reg == '0) ? RATE_W'(1) : pitch_accel_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    assign cur_yaw   = s_tdata[31:0];
    assign cur_pitch = s_tdata[63:32];
    assign tgt_yaw   = s_tdata[95:64];
    assign tgt_pitch = s_tdata[127:96];

    // yaw wrap: floor mod 45 on the coarse part, low 13 bits pass through
    assign s2_u    = {s1_dy_reg[DIST_W-1], s1_dy_reg[DIST_W-1:LO_BITS]} + WRAP_OFFSET;
    assign s2_prod = 43'(s2_u) * 43'(RECIP45);

    assign s3_r_raw = 22'(s2_u_reg) - 22'(s2_qest_reg) * 22'(COARSE_MOD);
    assign s3_r     = (s3_r_raw[6:0] >= COARSE_MOD) ? s3_r_raw[6:0] - COARSE_MOD
                                                    : s3_r_raw[6:0];

    assign s4_m_alt = TURN_UNITS - s3_m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= yaw_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dy_reg <= {tgt_yaw[ANGLE_W-1], tgt_yaw} - {cur_yaw[ANGLE_W-1], cur_yaw};
            s1_dp_reg <= {tgt_pitch[ANGLE_W-1], tgt_pitch}
                       - {cur_pitch[ANGLE_W-1], cur_pitch};

            s2_u_reg    <= s2_u;
            s2_lo_reg   <= s1_dy_reg[LO_BITS-1:0];
            s2_qest_reg <= s2_prod[42:RECIP_SHIFT];
            s2_pd_reg   <= s1_dp_reg[DIST_W-1] ? DIST_W'(-s1_dp_reg) : s1_dp_reg;

            s3_m_reg  <= {s3_r[5:0], s2_lo_reg};
            s3_pd_reg <= s2_pd_reg;

            s4_yd_reg <= DIST_W'((s3_m_reg > s4_m_alt) ? s4_m_alt : s3_m_reg);
            s4_pd_reg <= s3_pd_reg;

            m_data_reg <= enable_reg ? {total_time, pitch_time, yaw_time} : '0;
        end
    end

    mte_axis u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s4_valid_reg),
        .distance  (s4_yd_reg),
        .cfg       (yaw_cfg),
        .out_valid (yaw_valid),
        .time_us   (yaw_time)
    );

    mte_axis u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s4_valid_reg),
        .distance  (s4_pd_reg),
        .cfg       (pitch_cfg),
        .out_valid (pitch_valid),
        .time_us   (pitch_time)
    );

    assign big_time   = (yaw_time > pitch_time) ? yaw_time : pitch_time;
    assign settle_us  = 26'(settle_reg) * 26'(MS_TO_US);
    assign total_sum  = 33'(big_time) + 33'(settle_us);
    assign total_time = total_sum[TIME_W] ? TIME_SAT : total_sum[TIME_W-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_total_covers_axes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[95:64] >= m_tdata[31:0] && m_tdata[95:64] >= m_tdata[63:32])
        else $error("total below an axis time");

    a_axes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        yaw_valid == pitch_valid)
        else $error("axis pipelines out of step");

endmodule
